>>> sv/button_edge_latch_debounce_assert.svh
// assertion macros shared by the debounce edge latch modules
// no dependencies; included inside module bodies after the package import
`ifndef BUTTON_EDGE_LATCH_DEBOUNCE_ASSERT_SVH
`define BUTTON_EDGE_LATCH_DEBOUNCE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BELD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BELD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/beld_pkg.sv
// shared types, constants and helper functions for the debounce edge latch
// no dependencies
`default_nettype none

package beld_pkg;

    localparam int PIN_W           = 32;
    localparam int PIN_IDX_W       = 5;
    localparam int COUNT_W         = 8;
    localparam int LIVE_W          = 6;
    localparam int PIN_COUNT_DEF   = 32;
    localparam logic [31:0] HOLD_OFF_RESET = 32'd1000;
    localparam logic [31:0] TIMER_MAX      = 32'hFFFF_FFFF;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 3;
    localparam logic REG_HOLD_OFF = 1'b0;

    typedef enum logic [2:0] {
        FN_TICK         = 3'd0,
        FN_SAMPLE       = 3'd1,
        FN_TAKE_PRESS   = 3'd2,
        FN_TAKE_RELEASE = 3'd3,
        FN_LEVEL        = 3'd4,
        FN_ADD_SKIPS    = 3'd5,
        FN_CLEAR_ALL    = 3'd6,
        FN_NOP          = 3'd7
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [PIN_W-1:0]  now_bits;
        logic [PIN_W-1:0]  pin_mask;
        logic [COUNT_W-1:0] count;
    } t_item;

    function automatic logic [LIVE_W-1:0] live_count(input int pin_count);
        return (pin_count > PIN_W) ? LIVE_W'(PIN_W) : LIVE_W'(pin_count);
    endfunction

    function automatic logic [PIN_W-1:0] low_mask(input logic [LIVE_W-1:0] n);
        logic [PIN_W-1:0] m;
        for (int i = 0; i < PIN_W; i++) begin
            m[i] = (LIVE_W'(i) < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> sv/beld_front.sv
// front end: unpacks an input item and classifies it for the back end
// depends on beld_pkg
`default_nettype none

module beld_front #(
    parameter int PIN_COUNT = beld_pkg::PIN_COUNT_DEF
) (
    input  wire logic [beld_pkg::S_TDATA_W-1:0] i_tdata,  // raw_pins, pin, count
    input  wire logic [beld_pkg::S_TUSER_W-1:0] i_tuser,  // func
    output beld_pkg::t_item                     o_item
);
    import beld_pkg::*;

    localparam logic [LIVE_W-1:0] LiveCount = live_count(PIN_COUNT);
    localparam logic [PIN_W-1:0]  LiveMask  = low_mask(LiveCount);

    logic [PIN_W-1:0]     raw_pins;
    logic [PIN_IDX_W-1:0] pin;
    logic [COUNT_W-1:0]   count;
    logic                 pin_ok;
    t_func                func;

    assign raw_pins = i_tdata[31:0];
    assign pin      = i_tdata[36:32];
    assign count    = i_tdata[44:37];
    assign pin_ok   = {1'b0, pin} < LiveCount;

    always_comb begin
        unique case (i_tuser)
            3'd0:    func = FN_TICK;
            3'd1:    func = FN_SAMPLE;
            3'd2:    func = FN_TAKE_PRESS;
            3'd3:    func = FN_TAKE_RELEASE;
            3'd4:    func = FN_LEVEL;
            3'd5:    func = FN_ADD_SKIPS;
            3'd6:    func = FN_CLEAR_ALL;
            default: func = FN_NOP;
        endcase
    end

    always_comb begin
        o_item.func     = func;
        o_item.now_bits = ~raw_pins & LiveMask;
        o_item.pin_mask = pin_ok ? (PIN_W'(1) << pin) : '0;
        o_item.count    = count;
    end

endmodule

`default_nettype wire

>>> sv/beld_fifo.sv
// short item queue between the front and back ends
// depends on beld_pkg and the shared assertion header
`default_nettype none

module beld_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output      logic           o_push_ready,
    input  wire beld_pkg::t_item i_push_item,
    output      logic           o_pop_valid,
    input  wire logic           i_pop_ready,
    output beld_pkg::t_item     o_pop_item
);
    import beld_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

`include "button_edge_latch_debounce_assert.svh"

    `BELD_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
    `BELD_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop,
        r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

>>> sv/beld_back.sv
// back end: applies classified items to the latch state, registers the result
// depends on beld_pkg and the shared assertion header
`default_nettype none

module beld_back #(
    parameter int PIN_COUNT = beld_pkg::PIN_COUNT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [31:0]                      i_hold_off,
    input  wire logic                             i_q_valid,
    output      logic                             o_q_ready,
    input  wire beld_pkg::t_item                  i_q_item,
    output      logic                             o_tvalid,
    input  wire logic                             i_tready,
    output      logic [beld_pkg::M_TDATA_W-1:0]   o_tdata  // answer, pressed_pins, sample_taken
);
    import beld_pkg::*;

    localparam logic [LIVE_W-1:0] LiveCount = live_count(PIN_COUNT);
    localparam logic [PIN_W-1:0]  LiveMask  = low_mask(LiveCount);

    logic [PIN_W-1:0]   r_level, n_level;
    logic [PIN_W-1:0]   r_press, n_press;
    logic [PIN_W-1:0]   r_release, n_release;
    logic [31:0]        r_timer, n_timer;
    logic [COUNT_W-1:0] r_skips, n_skips;

    logic               r_out_valid;
    logic               r_out_answer, n_answer;
    logic [PIN_W-1:0]   r_out_pressed;
    logic               r_out_taken, n_taken;

    logic               fire;
    logic [LIVE_W-1:0]  clear_k;

    assign fire      = i_q_valid && (!r_out_valid || i_tready);
    assign o_q_ready = !r_out_valid || i_tready;
    assign clear_k   = (r_skips > COUNT_W'(LiveCount)) ? LiveCount : r_skips[LIVE_W-1:0];

    always_comb begin
        n_level   = r_level;
        n_press   = r_press;
        n_release = r_release;
        n_timer   = r_timer;
        n_skips   = r_skips;
        n_answer  = 1'b0;
        n_taken   = 1'b0;
        unique case (i_q_item.func)
            FN_TICK: begin
                if (r_timer != TIMER_MAX) begin
                    n_timer = r_timer + 1'b1;
                end
            end
            FN_SAMPLE: begin
                if (r_timer > i_hold_off) begin
                    n_press   = r_press | (i_q_item.now_bits & ~r_level);
                    n_release = r_release | (~i_q_item.now_bits & r_level);
                    n_level   = i_q_item.now_bits;
                    n_taken   = 1'b1;
                    if (i_q_item.now_bits != r_level) begin
                        n_timer = '0;
                    end
                end
            end
            FN_TAKE_PRESS: begin
                if ((r_press & i_q_item.pin_mask) != '0) begin
                    n_press  = r_press & ~i_q_item.pin_mask;
                    n_answer = 1'b1;
                end
            end
            FN_TAKE_RELEASE: begin
                if (r_skips != '0) begin
                    n_skips  = r_skips - 1'b1;
                    n_answer = 1'b1;
                end else if ((r_release & i_q_item.pin_mask) != '0) begin
                    n_release = r_release & ~i_q_item.pin_mask;
                    n_answer  = 1'b1;
                end
            end
            FN_LEVEL: begin
                n_answer = (r_level & i_q_item.pin_mask) != '0;
            end
            FN_ADD_SKIPS: begin
                n_skips = r_skips + i_q_item.count;
            end
            FN_CLEAR_ALL: begin
                n_skips   = r_skips - COUNT_W'(clear_k);
                n_release = r_release & (low_mask(clear_k) | ~LiveMask);
                n_press   = r_press & ~LiveMask;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_press     <= '0;
            r_release   <= '0;
            r_timer     <= '0;
            r_skips     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_level     <= n_level;
                r_press     <= n_press;
                r_release   <= n_release;
                r_timer     <= n_timer;
                r_skips     <= n_skips;
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_answer  <= n_answer;
            r_out_pressed <= n_level;
            r_out_taken   <= n_taken;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {6'b0, r_out_taken, r_out_pressed, r_out_answer};

`include "button_edge_latch_debounce_assert.svh"

    `BELD_ASSERT_NEXT(a_tick_keeps_pins, i_clk, i_rst_n,
        fire && i_q_item.func == FN_TICK,
        $stable(r_level) && $stable(r_skips) && $stable(r_press),
        "tick changed pin state")
    `BELD_ASSERT_NEXT(a_taken_only_sample, i_clk, i_rst_n,
        fire && i_q_item.func != FN_SAMPLE, !r_out_taken,
        "sample flag on a non-sample item")
    `BELD_ASSERT_IMPLY(a_live_only, i_clk, i_rst_n, 1'b1,
        ((r_level | r_press | r_release) & ~LiveMask) == '0,
        "state bit set on an absent pin")

endmodule

`default_nettype wire

>>> sv/button_edge_latch_debounce.sv
// Debounced edge latch for up to 32 active-low button pins.
// Input channel (s_axis): one operation per item, func in tuser; raw_pins,
//   pin and count in tdata. Output channel (m_axis): exactly one result per
//   item, in order: answer, pressed_pins and sample_taken in tdata.
// Configuration: APB port, register 0 at address 0 is hold_off_ticks.
//   A sample is taken only when the tick timer exceeds it.
// Result path: an accepted item is written into the queue, then the back end
//   applies it and loads its result into the output register that drives m_axis.
// Throughput: one item per cycle while tready is high, set by the state update
//   of the back end; the two-entry queue decouples input acceptance from output.
// Reset: pin levels, sticky press/release bits, the timer and skip credits
//   clear to zero, hold_off_ticks returns to 1000, both channels empty.
// Stall: when the receiver holds tready low the result stays registered, the
//   back end stops, the queue fills, and s_axis_tready drops once it is full.
// depends on beld_pkg, beld_front, beld_fifo, beld_back
`default_nettype none

module button_edge_latch_debounce #(
    parameter int PIN_COUNT = beld_pkg::PIN_COUNT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output      logic                                 o_s_axis_tready,
    // raw_pins[31:0], pin[36:32], count[44:37], zero fill
    input  wire logic [beld_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    // func[2:0]
    input  wire logic [beld_pkg::S_TUSER_W-1:0]       i_s_axis_tuser,
    output      logic                                 o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // answer[0], pressed_pins[32:1], sample_taken[33], zero fill
    output      logic [beld_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [beld_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [31:0]                          pwdata,
    output      logic [31:0]                          prdata,
    output      logic                                 pready
);
    import beld_pkg::*;

    logic [31:0] r_hold_off;
    logic        reg_sel;
    t_item       front_item;
    t_item       q_item;
    logic        q_valid;
    logic        q_ready;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == REG_HOLD_OFF;
    assign prdata  = reg_sel ? r_hold_off : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_off <= HOLD_OFF_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_hold_off <= pwdata;
        end
    end

    beld_front #(
        .PIN_COUNT (PIN_COUNT)
    ) u_front (
        .i_tdata (i_s_axis_tdata),
        .i_tuser (i_s_axis_tuser),
        .o_item  (front_item)
    );

    beld_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_s_axis_tvalid),
        .o_push_ready (o_s_axis_tready),
        .i_push_item  (front_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    beld_back #(
        .PIN_COUNT (PIN_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold_off (r_hold_off),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_item   (q_item),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// testbench for button_edge_latch_debounce: drives operations on the stream input,
// predicts every result in a scoreboard class and checks the stream output in order
// depends on beld_pkg and button_edge_latch_debounce
module tb_top;
    import beld_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int LIVE_PINS = (PIN_COUNT_DEF > 32) ? 32 : PIN_COUNT_DEF;
    localparam logic [31:0] LIVE_MASK =
        (LIVE_PINS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << LIVE_PINS) - 32'd1);
    localparam logic [APB_ADDR_W-1:0] HOLD_OFF_ADDR = APB_ADDR_W'(4 * int'(REG_HOLD_OFF));

    typedef struct packed {
        logic        answer;
        logic [31:0] pressed;
        logic        taken;
    } t_latch_result;

    class latch_scoreboard;
        logic [31:0]   hold_off;
        logic [31:0]   level_bits;
        logic [31:0]   press_bits;
        logic [31:0]   release_bits;
        logic [31:0]   hold_timer;
        logic [7:0]    credits;
        t_latch_result due_results[$];
        int unsigned   errors;

        function new();
            hold_off = HOLD_OFF_RESET;
            level_bits = '0;
            press_bits = '0;
            release_bits = '0;
            hold_timer = '0;
            credits = '0;
            errors = 0;
        endfunction

        task log_mismatch(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        // update the latch state for one accepted item and queue its result
        function void note_item(t_func op, logic [31:0] raw, logic [4:0] pin,
                                logic [7:0] cnt);
            t_latch_result r;
            logic [31:0]   bit_sel;
            logic [31:0]   now;
            logic [31:0]   keep;
            logic          pin_ok;
            int            k;
            r = '0;
            bit_sel = 32'd1 << pin;
            pin_ok = int'(pin) < LIVE_PINS;
            case (op)
                FN_TICK: begin
                    if (hold_timer != TIMER_MAX) hold_timer++;
                end
                FN_SAMPLE: begin
                    if (hold_timer > hold_off) begin
                        now = ~raw & LIVE_MASK;
                        press_bits |= now & ~level_bits;
                        release_bits |= ~now & level_bits & LIVE_MASK;
                        if (now != level_bits) hold_timer = '0;
                        level_bits = now;
                        r.taken = 1'b1;
                    end
                end
                FN_TAKE_PRESS: begin
                    if (pin_ok && (press_bits & bit_sel) != 0) begin
                        press_bits &= ~bit_sel;
                        r.answer = 1'b1;
                    end
                end
                FN_TAKE_RELEASE: begin
                    if (credits != 0) begin
                        credits--;
                        r.answer = 1'b1;
                    end else if (pin_ok && (release_bits & bit_sel) != 0) begin
                        release_bits &= ~bit_sel;
                        r.answer = 1'b1;
                    end
                end
                FN_LEVEL: begin
                    r.answer = pin_ok && ((level_bits & bit_sel) != 0);
                end
                FN_ADD_SKIPS: begin
                    credits = credits + cnt;
                end
                FN_CLEAR_ALL: begin
                    // lowest pins keep their release bit while credits last
                    k = (int'(credits) > LIVE_PINS) ? LIVE_PINS : int'(credits);
                    credits = credits - 8'(k);
                    keep = (k >= 32) ? 32'hFFFF_FFFF : ((32'd1 << k) - 32'd1);
                    release_bits &= keep | ~LIVE_MASK;
                    press_bits &= ~LIVE_MASK;
                end
                default: begin
                end
            endcase
            r.pressed = level_bits;
            due_results.push_back(r);
        endfunction

        task check_result(logic answer, logic [31:0] pressed, logic taken);
            t_latch_result want;
            if (due_results.size() == 0) begin
                log_mismatch("result with no item outstanding");
                return;
            end
            want = due_results.pop_front();
            if (answer !== want.answer)
                log_mismatch($sformatf("answer %b, want %b", answer, want.answer));
            if (pressed !== want.pressed)
                log_mismatch($sformatf("pressed_pins %h, want %h", pressed, want.pressed));
            if (taken !== want.taken)
                log_mismatch($sformatf("sample_taken %b, want %b", taken, want.taken));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // raw_pins[31:0], pin[36:32], count[44:37], zero fill
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    // func[2:0]
    logic [S_TUSER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // answer[0], pressed_pins[32:1], sample_taken[33], zero fill
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    latch_scoreboard sb;
    int unsigned     cycle_count = 0;
    int unsigned     send_gap_pct = 0;
    int unsigned     recv_stall_pct = 0;
    logic [31:0]     raw_track = 32'hFFFF_FFFF;

    button_edge_latch_debounce u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("button_edge_latch_debounce regression: fail");
        $finish;
    end

    // result side: check on handshake, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata[0], o_m_axis_tdata[32:1], o_m_axis_tdata[33]);
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_op(t_func op, logic [31:0] raw, logic [4:0] pin, logic [7:0] cnt);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= {3'b000, cnt, pin, raw};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_item(op, raw, pin, cnt);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write hold_off_ticks, then read it back
    task automatic set_hold_off(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HOLD_OFF_ADDR;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.hold_off = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value)
            sb.log_mismatch($sformatf("hold_off_ticks read %h, want %h", prdata, value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_item();
        int unsigned pick;
        int unsigned shape;
        t_func       op;
        logic [31:0] raw;
        logic [7:0]  cnt;
        pick = $urandom_range(99);
        raw = $urandom;
        cnt = ($urandom_range(99) < 5) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
        if (pick < 30) begin
            op = FN_TICK;
        end else if (pick < 52) begin
            op = FN_SAMPLE;
            // mostly small changes to the pins so edges stay sparse
            shape = $urandom_range(99);
            if (shape < 50)
                raw_track ^= (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
            else if (shape < 70)
                raw_track = $urandom;
            else if (shape < 78)
                raw_track = '1;
            else if (shape < 84)
                raw_track = '0;
            raw = raw_track;
        end else if (pick < 64) begin
            op = FN_TAKE_PRESS;
        end else if (pick < 76) begin
            op = FN_TAKE_RELEASE;
        end else if (pick < 84) begin
            op = FN_LEVEL;
        end else if (pick < 90) begin
            op = FN_ADD_SKIPS;
        end else if (pick < 95) begin
            op = FN_CLEAR_ALL;
        end else begin
            op = FN_NOP;
        end
        send_op(op, raw, 5'($urandom_range(31)), cnt);
    endtask

    initial begin
        logic [31:0] phase_hold[6];
        int unsigned phase_gap[6];
        int unsigned phase_stall[6];
        int unsigned phase_items[6];
        logic [31:0] hold;
        phase_hold = '{32'd0, 32'd1, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'd2};
        phase_gap = '{0, 81, 0, 28, 0, 81};
        phase_stall = '{0, 0, 81, 28, 81, 0};
        phase_items = '{500, 400, 400, 400, 150, 150};
        sb = new();
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tuser <= '0;
        i_m_axis_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset hold-off rejects the first sample
        send_op(FN_SAMPLE, 32'h0000_0000, 5'd0, 8'd0);
        drain();
        set_hold_off(32'd0);
        send_op(FN_TICK, 32'hFFFF_FFFF, 5'd31, 8'd255);
        send_op(FN_SAMPLE, 32'h0000_0000, 5'd0, 8'd0);
        send_op(FN_TAKE_PRESS, 32'h0000_0000, 5'd0, 8'd0);
        send_op(FN_TAKE_PRESS, 32'h0000_0000, 5'd0, 8'd0);
        send_op(FN_LEVEL, 32'h0000_0000, 5'd31, 8'd0);
        // timer restarted by the change, so this one is dropped
        send_op(FN_SAMPLE, 32'hFFFF_FFFF, 5'd0, 8'd0);
        send_op(FN_TICK, 32'h0000_0000, 5'd0, 8'd0);
        send_op(FN_SAMPLE, 32'hFFFF_FFFF, 5'd0, 8'd0);
        send_op(FN_TAKE_RELEASE, 32'h0000_0000, 5'd31, 8'd0);
        send_op(FN_TAKE_RELEASE, 32'h0000_0000, 5'd31, 8'd0);
        send_op(FN_LEVEL, 32'h0000_0000, 5'd0, 8'd0);
        // credits wrap past 255
        send_op(FN_ADD_SKIPS, 32'h0000_0000, 5'd0, 8'd255);
        send_op(FN_ADD_SKIPS, 32'h0000_0000, 5'd0, 8'd2);
        send_op(FN_TAKE_RELEASE, 32'h0000_0000, 5'd9, 8'd0);
        send_op(FN_TAKE_RELEASE, 32'h0000_0000, 5'd9, 8'd0);
        send_op(FN_ADD_SKIPS, 32'h0000_0000, 5'd0, 8'd3);
        send_op(FN_CLEAR_ALL, 32'h0000_0000, 5'd0, 8'd0);
        send_op(FN_TAKE_RELEASE, 32'h0000_0000, 5'd1, 8'd0);
        send_op(FN_TAKE_RELEASE, 32'h0000_0000, 5'd5, 8'd0);
        send_op(FN_TAKE_PRESS, 32'h0000_0000, 5'd7, 8'd0);
        send_op(FN_NOP, 32'hFFFF_FFFF, 5'd31, 8'd255);
        send_op(FN_ADD_SKIPS, 32'h0000_0000, 5'd0, 8'd0);
        send_op(FN_TICK, 32'h0000_0000, 5'd0, 8'd0);
        send_op(FN_SAMPLE, 32'hA5A5_5A5A, 5'd0, 8'd0);
        drain();

        for (int p = 0; p < 6; p++) begin
            hold = (p == 3) ? 32'($urandom_range(7)) : phase_hold[p];
            set_hold_off(hold);
            send_gap_pct = phase_gap[p];
            recv_stall_pct = phase_stall[p];
            repeat (phase_items[p]) send_random_item();
            drain();
        end
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("button_edge_latch_debounce regression: pass");
        end else begin
            $display("button_edge_latch_debounce regression: fail");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/beld_pkg.sv
sv/beld_front.sv
sv/beld_fifo.sv
sv/beld_back.sv
sv/button_edge_latch_debounce.sv
verif/tb_top.sv
